// ===== design/tdau_pkg.sv =====
package tdau_pkg;

    localparam int NumSlots = 4;
    localparam int SlotW    = 2;
    localparam int HourW    = 5;
    localparam int MinW     = 6;
    localparam int SecW     = 6;

    localparam logic [HourW-1:0] HoursPerDay = 5'd24;
    localparam logic [HourW-1:0] LastHour    = 5'd23;
    localparam logic [MinW-1:0]  LastMinute  = 6'd59;
    localparam logic [SecW-1:0]  LastSecond  = 6'd59;
    localparam logic [SecW-1:0]  RingStopSec = 6'd30;
    localparam logic [MinW:0]    MinPerHour  = 7'd60;
    localparam logic [MinW:0]    SnoozeMin   = 7'd2;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_SET_TIME = 3'd1,
        OP_ADD      = 3'd2,
        OP_DELETE   = 3'd3,
        OP_SNOOZE   = 3'd4,
        OP_DISMISS  = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [HourW-1:0] hour_value;
        logic [MinW-1:0]  minute_value;
        logic [SlotW-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [HourW-1:0] cur_hours;
        logic [MinW-1:0]  cur_minutes;
        logic [SecW-1:0]  cur_seconds;
        logic             ringing;
        logic [SlotW-1:0] ring_slot;
        logic             slots_full;
        logic [SlotW-1:0] added_slot;
    } t_out_item;

    typedef struct packed {
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
    } t_time;

    typedef struct packed {
        logic             hit;
        logic [SlotW-1:0] hit_idx;
        logic             full;
        logic [SlotW-1:0] added;
    } t_slot_status;

    // hour + 1 modulo 24, for any 5-bit hour
    function automatic logic [HourW-1:0] hour_inc(input logic [HourW-1:0] h);
        logic [HourW:0] s;
        s = {1'b0, h} + {{HourW{1'b0}}, 1'b1};
        if (s >= {1'b0, HoursPerDay}) begin
            s = s - {1'b0, HoursPerDay};
        end
        return s[HourW-1:0];
    endfunction

endpackage

// ===== design/tdau_in_if.sv =====
interface tdau_in_if;
    logic               valid;
    logic               ready;
    tdau_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/tdau_out_if.sv =====
interface tdau_out_if;
    logic                valid;
    logic                ready;
    tdau_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/time_of_day_alarm_unit.sv =====
// Time-of-day clock with four alarm slots.
// i_in carries one command beat: opcode (tick, set time, add alarm, delete
// slot, snooze, dismiss) with hour, minute and slot operands. o_out returns
// exactly one beat per command: the time, the ringing flag and slot, and the
// add-alarm outcome, all as they stand after that command.
// A beat is taken into an input register, then evaluated combinationally into
// the output register; o_out.valid rises when the result is written there, and
// one command is accepted every cycle while o_out drains.
// The time counters, the slot table and the ring state are updated with each
// result, and the next command reads them.
// Reset (i_rst_n low, synchronous) clears the time to 00:00:00, frees all
// slots, stops ringing and empties both registers.
// When the receiver holds o_out.ready low, the result beat is held, one more
// command waits in the input register, then i_in.ready drops until the
// result is taken.
module time_of_day_alarm_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tdau_in_if.sink      i_in,
    tdau_out_if.source   o_out
);

    logic                       r_in_valid;
    tdau_pkg::t_in_item         r_in;
    logic                       r_out_valid;
    tdau_pkg::t_out_item        r_out;
    logic                       r_ring_active;
    logic [tdau_pkg::SlotW-1:0] r_ring_index;

    logic                       n_ring_active;
    logic [tdau_pkg::SlotW-1:0] n_ring_index;
    tdau_pkg::t_out_item        n_out;

    logic                       w_adv;
    tdau_pkg::t_time            w_time;
    tdau_pkg::t_slot_status     w_slot;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    tdau_clock u_clock (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_opcode       (r_in.opcode),
        .i_hour_value   (r_in.hour_value),
        .i_minute_value (r_in.minute_value),
        .o_next         (w_time)
    );

    tdau_slots u_slots (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_opcode       (r_in.opcode),
        .i_hour_value   (r_in.hour_value),
        .i_minute_value (r_in.minute_value),
        .i_slot_index   (r_in.slot_index),
        .i_ring_active  (r_ring_active),
        .i_ring_index   (r_ring_index),
        .i_time         (w_time),
        .o_status       (w_slot)
    );

    always_comb begin
        n_ring_active = r_ring_active;
        n_ring_index  = r_ring_index;
        unique case (r_in.opcode)
            tdau_pkg::OP_TICK: begin
                if (r_ring_active) begin
                    if (w_time.second == tdau_pkg::RingStopSec) begin
                        n_ring_active = 1'b0;
                    end
                end else if (w_time.second == '0 && w_slot.hit) begin
                    n_ring_active = 1'b1;
                    n_ring_index  = w_slot.hit_idx;
                end
            end
            tdau_pkg::OP_SNOOZE, tdau_pkg::OP_DISMISS: begin
                n_ring_active = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out.cur_hours   = w_time.hour;
        n_out.cur_minutes = w_time.minute;
        n_out.cur_seconds = w_time.second;
        n_out.ringing     = n_ring_active;
        n_out.ring_slot   = n_ring_active ? n_ring_index : '0;
        n_out.slots_full  = w_slot.full;
        n_out.added_slot  = w_slot.added;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ring_active <= 1'b0;
            r_ring_index  <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid   <= 1'b1;
                r_ring_active <= n_ring_active;
                r_ring_index  <= n_ring_index;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

endmodule

// ===== design/tdau_clock.sv =====
module tdau_clock (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [2:0]                     i_opcode,
    input  logic [tdau_pkg::HourW-1:0]     i_hour_value,
    input  logic [tdau_pkg::MinW-1:0]      i_minute_value,
    output tdau_pkg::t_time                o_next
);

    tdau_pkg::t_time r_time;
    tdau_pkg::t_time n_time;

    always_comb begin
        n_time = r_time;
        unique case (i_opcode)
            tdau_pkg::OP_TICK: begin
                if (r_time.second >= tdau_pkg::LastSecond) begin
                    n_time.second = '0;
                    if (r_time.minute >= tdau_pkg::LastMinute) begin
                        n_time.minute = '0;
                        n_time.hour   = tdau_pkg::hour_inc(r_time.hour);
                    end else begin
                        n_time.minute = r_time.minute + 1'b1;
                    end
                end else begin
                    n_time.second = r_time.second + 1'b1;
                end
            end
            tdau_pkg::OP_SET_TIME: begin
                if (i_hour_value <= tdau_pkg::LastHour &&
                    i_minute_value <= tdau_pkg::LastMinute) begin
                    n_time.hour   = i_hour_value;
                    n_time.minute = i_minute_value;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_next = n_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_en) begin
            r_time <= n_time;
        end
    end

endmodule

// ===== design/tdau_slots.sv =====
module tdau_slots (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [2:0]                     i_opcode,
    input  logic [tdau_pkg::HourW-1:0]     i_hour_value,
    input  logic [tdau_pkg::MinW-1:0]      i_minute_value,
    input  logic [tdau_pkg::SlotW-1:0]     i_slot_index,
    input  logic                           i_ring_active,
    input  logic [tdau_pkg::SlotW-1:0]     i_ring_index,
    input  tdau_pkg::t_time                i_time,
    output tdau_pkg::t_slot_status         o_status
);

    logic [tdau_pkg::HourW-1:0] r_hour [tdau_pkg::NumSlots];
    logic [tdau_pkg::MinW-1:0]  r_min  [tdau_pkg::NumSlots];
    logic [tdau_pkg::NumSlots-1:0] r_free;

    logic                        w_any_free;
    logic [tdau_pkg::SlotW-1:0]  w_free_idx;
    logic                        w_hit;
    logic [tdau_pkg::SlotW-1:0]  w_hit_idx;
    logic [tdau_pkg::MinW:0]     w_snz_sum;
    logic [tdau_pkg::MinW-1:0]   w_snz_min;
    logic                        w_snz_carry;
    logic                        w_is_add;

    // lowest free slot and lowest occupied slot matching the clock
    always_comb begin
        w_any_free = 1'b0;
        w_free_idx = '0;
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        for (int i = tdau_pkg::NumSlots - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_any_free = 1'b1;
                w_free_idx = tdau_pkg::SlotW'(i);
            end
            if (!r_free[i] && r_hour[i] == i_time.hour && r_min[i] == i_time.minute) begin
                w_hit     = 1'b1;
                w_hit_idx = tdau_pkg::SlotW'(i);
            end
        end
    end

    always_comb begin
        w_snz_sum   = {1'b0, r_min[i_ring_index]} + tdau_pkg::SnoozeMin;
        w_snz_carry = (w_snz_sum >= tdau_pkg::MinPerHour);
        if (w_snz_carry) begin
            w_snz_min = tdau_pkg::MinW'(w_snz_sum - tdau_pkg::MinPerHour);
        end else begin
            w_snz_min = w_snz_sum[tdau_pkg::MinW-1:0];
        end
    end

    assign w_is_add = (i_opcode == tdau_pkg::OP_ADD);

    assign o_status.hit     = w_hit;
    assign o_status.hit_idx = w_hit_idx;
    assign o_status.full    = w_is_add && !w_any_free;
    assign o_status.added   = (w_is_add && w_any_free) ? w_free_idx : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            for (int i = 0; i < tdau_pkg::NumSlots; i++) begin
                r_hour[i] <= '0;
                r_min[i]  <= '0;
            end
        end else if (i_en) begin
            unique case (i_opcode)
                tdau_pkg::OP_ADD: begin
                    if (w_any_free) begin
                        r_hour[w_free_idx] <= i_hour_value;
                        r_min[w_free_idx]  <= i_minute_value;
                        r_free[w_free_idx] <= 1'b0;
                    end
                end
                tdau_pkg::OP_DELETE: begin
                    r_free[i_slot_index] <= 1'b1;
                end
                tdau_pkg::OP_SNOOZE: begin
                    if (i_ring_active) begin
                        r_min[i_ring_index] <= w_snz_min;
                        if (w_snz_carry) begin
                            r_hour[i_ring_index] <= tdau_pkg::hour_inc(r_hour[i_ring_index]);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
